// File: hdl/rvmx_pkg.sv
// ----------------------------------------------------------------------------
// rvmx_pkg
// shared types and constants of the register vm execute unit
// ----------------------------------------------------------------------------
`default_nettype none

package rvmx_pkg;

  localparam int unsigned DataW             = 32;
  localparam int unsigned RegIdxW           = 8;
  localparam int unsigned LabelW            = 16;
  localparam int unsigned FuncW             = 5;
  localparam int unsigned NumRegsDefault    = 256;
  localparam int unsigned StackDepthDefault = 256;
  localparam int unsigned InTdataW          = 72;
  localparam int unsigned OutTdataW         = 64;

  typedef enum logic [FuncW-1:0] {
    FN_RET   = 5'd0,  FN_LETI  = 5'd1,  FN_REV   = 5'd2,  FN_JMP   = 5'd3,
    FN_JEQ   = 5'd4,  FN_JNE   = 5'd5,  FN_JGT   = 5'd6,  FN_JLT   = 5'd7,
    FN_JGE   = 5'd8,  FN_JLE   = 5'd9,  FN_JEQI  = 5'd10, FN_JNEI  = 5'd11,
    FN_JGTI  = 5'd12, FN_JLTI  = 5'd13, FN_JGEI  = 5'd14, FN_JLEI  = 5'd15,
    FN_ADDI  = 5'd16, FN_SUBI  = 5'd17, FN_MULI  = 5'd18, FN_DIVI  = 5'd19,
    FN_ADD   = 5'd20, FN_SUB   = 5'd21, FN_MUL   = 5'd22, FN_DIV   = 5'd23,
    FN_PUSH  = 5'd24, FN_POP   = 5'd25, FN_NOP   = 5'd26
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2,
    ST_DIVZ  = 2'd3
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture the accepted instruction
    logic rd_a;     // register file read of reg_a, stack read
    logic rd_b;     // capture a, read reg_b
    logic exec;     // evaluate the instruction
    logic div_cap;  // take the quotient
    logic commit;   // update state and fill the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_go;   // exec started a division
    logic div_done;
    logic out_free; // output register can take a result this cycle
  } sts_t;

endpackage

`default_nettype wire

// File: hdl/rvmx_ram.sv
// ----------------------------------------------------------------------------
// rvmx_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module rvmx_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: hdl/rvmx_div.sv
// ----------------------------------------------------------------------------
// rvmx_div
// signed 32-bit divider, restoring, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module rvmx_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [rvmx_pkg::DataW-1:0] a_i,
  input  wire logic [rvmx_pkg::DataW-1:0] b_i,
  output logic                            done_o,
  output logic      [rvmx_pkg::DataW-1:0] q_o
);
  import rvmx_pkg::*;

  localparam int unsigned CntW = $clog2(DataW);

  logic            busy_q, fix_q, neg_q;
  logic [CntW-1:0] cnt_q;
  logic [DataW-1:0] num_q, den_q, rem_q;
  logic [DataW:0]   trial;

  assign trial = {rem_q, num_q[DataW-1]} - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fix_q  <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      fix_q  <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(DataW - 1)) begin
          busy_q <= 1'b0;
          fix_q  <= 1'b1;
        end
      end
      if (fix_q) begin
        done_o <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= a_i[DataW-1] ^ b_i[DataW-1];
      num_q <= a_i[DataW-1] ? (~a_i + 1'b1) : a_i;
      den_q <= b_i[DataW-1] ? (~b_i + 1'b1) : b_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= trial[DataW] ? {rem_q[DataW-2:0], num_q[DataW-1]} : trial[DataW-1:0];
      num_q <= {num_q[DataW-2:0], ~trial[DataW]};
    end
    if (fix_q) begin
      q_o <= neg_q ? (~num_q + 1'b1) : num_q;
    end
  end

endmodule

`default_nettype wire

// File: hdl/rvmx_ctrl.sv
// ----------------------------------------------------------------------------
// rvmx_ctrl
// instruction sequencer of the execute unit
// ----------------------------------------------------------------------------
`default_nettype none

module rvmx_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire rvmx_pkg::sts_t sts_i,
  output rvmx_pkg::cmd_t      cmd_o
);
  import rvmx_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_RDA, S_RDB, S_EXEC, S_DIV, S_COMMIT
  } state_e;

  state_e state_q;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o         = '0;
    cmd_o.load    = in_ready_o && in_valid_i;
    cmd_o.rd_a    = (state_q == S_RDA);
    cmd_o.rd_b    = (state_q == S_RDB);
    cmd_o.exec    = (state_q == S_EXEC);
    cmd_o.div_cap = (state_q == S_DIV) && sts_i.div_done;
    cmd_o.commit  = (state_q == S_COMMIT) && sts_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      unique case (state_q)
        S_IDLE:   if (in_valid_i) state_q <= S_RDA;
        S_RDA:    state_q <= S_RDB;
        S_RDB:    state_q <= S_EXEC;
        S_EXEC:   state_q <= sts_i.div_go ? S_DIV : S_COMMIT;
        S_DIV:    if (sts_i.div_done) state_q <= S_COMMIT;
        S_COMMIT: if (sts_i.out_free) state_q <= S_IDLE;
        default:  state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hdl/rvmx_dp.sv
// ----------------------------------------------------------------------------
// rvmx_dp
// datapath: register file, stack, alu, divider and output register
// ----------------------------------------------------------------------------
`default_nettype none

module rvmx_dp #(
  parameter int unsigned NUM_REGS    = rvmx_pkg::NumRegsDefault,
  parameter int unsigned STACK_DEPTH = rvmx_pkg::StackDepthDefault
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire rvmx_pkg::cmd_t               cmd_i,
  output rvmx_pkg::sts_t                    sts_o,
  input  wire logic [rvmx_pkg::FuncW-1:0]   func_i,
  input  wire logic [rvmx_pkg::RegIdxW-1:0] reg_a_i,
  input  wire logic [rvmx_pkg::RegIdxW-1:0] reg_b_i,
  input  wire logic [rvmx_pkg::DataW-1:0]   immediate_i,
  input  wire logic [rvmx_pkg::LabelW-1:0]  label_i,
  input  wire logic                         out_ready_i,
  output logic                              out_valid_o,
  output logic                              halted_o,
  output logic                              jump_taken_o,
  output logic      [rvmx_pkg::LabelW-1:0]  jump_label_o,
  output logic                              reg_written_o,
  output logic      [rvmx_pkg::RegIdxW-1:0] write_index_o,
  output logic      [rvmx_pkg::DataW-1:0]   write_value_o,
  output logic      [1:0]                   status_o
);
  import rvmx_pkg::*;

  localparam int unsigned RaW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int unsigned SaW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned SdW = $clog2(STACK_DEPTH + 1);
  localparam logic [RegIdxW:0] NumRegsC = (RegIdxW + 1)'(NUM_REGS);
  localparam logic [SdW-1:0]   FullC    = SdW'(STACK_DEPTH);

  // instruction
  func_e                func_q;
  logic [RegIdxW-1:0]   ra_q, rb_q;
  logic [DataW-1:0]     imm_q;
  logic [LabelW-1:0]    lab_q;

  // operands and results
  logic [DataW-1:0]     va_q, pop_q, wval_q;
  logic                 halt_q, jt_q, wr_q;
  status_e              st_q;

  logic [NUM_REGS-1:0]  rf_vld_q;
  logic [SdW-1:0]       sd_q;
  logic                 pushed_q;

  logic [RaW-1:0]       rf_raddr;
  logic [DataW-1:0]     rf_rdata, stk_rdata, vb, src, other, mul_res;
  logic [SdW-1:0]       sd_dec;
  logic                 ra_in, rb_in, a_ok, b_ok, cmp_eq, cmp_gt, cond;
  logic                 div_done;
  logic [DataW-1:0]     div_q;
  logic                 wr_fin, stk_we, is_push, is_pop;

  assign ra_in  = ({1'b0, ra_q} < NumRegsC);
  assign rb_in  = ({1'b0, rb_q} < NumRegsC);
  assign a_ok   = ra_in && rf_vld_q[ra_q[RaW-1:0]];
  assign b_ok   = rb_in && rf_vld_q[rb_q[RaW-1:0]];
  assign rf_raddr = cmd_i.rd_b ? rb_q[RaW-1:0] : ra_q[RaW-1:0];
  assign vb     = b_ok ? rf_rdata : '0;
  assign sd_dec = (sd_q == '0) ? '0 : sd_q - 1'b1;
  assign wr_fin = wr_q && ra_in;
  assign is_push = (func_q == FN_PUSH);
  assign is_pop  = (func_q == FN_POP);
  assign stk_we  = cmd_i.commit && is_push && (sd_q != FullC);

  rvmx_ram #(.Width(DataW), .Depth(NUM_REGS)) u_rf (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit && wr_fin),
    .waddr_i (ra_q[RaW-1:0]),
    .wdata_i (wval_q),
    .raddr_i (rf_raddr),
    .rdata_o (rf_rdata)
  );

  rvmx_ram #(.Width(DataW), .Depth(STACK_DEPTH)) u_stk (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (sd_q[SaW-1:0]),
    .wdata_i (va_q),
    .raddr_i (sd_dec[SaW-1:0]),
    .rdata_o (stk_rdata)
  );

  // operand selection and compare
  always_comb begin
    case (func_q) inside
      FN_ADDI, FN_SUBI, FN_MULI, FN_DIVI: src = imm_q;
      default:                            src = vb;
    endcase
    case (func_q) inside
      FN_JEQI, FN_JNEI, FN_JGTI, FN_JLTI, FN_JGEI, FN_JLEI: other = imm_q;
      default:                                             other = vb;
    endcase
    cmp_eq  = (va_q == other);
    cmp_gt  = ($signed(va_q) > $signed(other));
    mul_res = va_q * src;
    case (func_q) inside
      FN_JEQ, FN_JEQI: cond = cmp_eq;
      FN_JNE, FN_JNEI: cond = !cmp_eq;
      FN_JGT, FN_JGTI: cond = cmp_gt;
      FN_JLT, FN_JLTI: cond = !cmp_gt && !cmp_eq;
      FN_JGE, FN_JGEI: cond = cmp_gt || cmp_eq;
      FN_JLE, FN_JLEI: cond = !cmp_gt;
      FN_JMP:          cond = 1'b1;
      default:         cond = 1'b0;
    endcase
  end

  assign sts_o.div_go   = cmd_i.exec && (func_q == FN_DIV || func_q == FN_DIVI)
                          && (src != '0);
  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !out_valid_o || out_ready_i;

  rvmx_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sts_o.div_go),
    .a_i     (va_q),
    .b_i     (src),
    .done_o  (div_done),
    .q_o     (div_q)
  );

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_e'(func_i);
      ra_q   <= reg_a_i;
      rb_q   <= reg_b_i;
      imm_q  <= immediate_i;
      lab_q  <= label_i;
    end
    if (cmd_i.rd_b) begin
      va_q  <= a_ok ? rf_rdata : '0;
      pop_q <= pushed_q ? stk_rdata : '0;
    end
    if (cmd_i.exec) begin
      halt_q <= (func_q == FN_RET);
      jt_q   <= cond;
      wr_q   <= 1'b0;
      wval_q <= '0;
      st_q   <= ST_OK;
      case (func_q) inside
        FN_LETI: begin wr_q <= 1'b1; wval_q <= imm_q; end
        FN_REV:  begin wr_q <= 1'b1; wval_q <= {{(DataW-1){1'b0}}, (va_q == '0)}; end
        FN_ADD, FN_ADDI: begin wr_q <= 1'b1; wval_q <= va_q + src; end
        FN_SUB, FN_SUBI: begin wr_q <= 1'b1; wval_q <= va_q - src; end
        FN_MUL, FN_MULI: begin wr_q <= 1'b1; wval_q <= mul_res; end
        FN_DIV, FN_DIVI: begin
          if (src == '0) st_q <= ST_DIVZ;
          else           wr_q <= 1'b1;
        end
        FN_PUSH: if (sd_q == FullC) st_q <= ST_OVER;
        FN_POP: begin
          wr_q   <= 1'b1;
          wval_q <= pop_q;
          if (sd_q == '0) st_q <= ST_UNDER;
        end
        default: ;
      endcase
    end
    if (cmd_i.div_cap) begin
      wval_q <= div_q;
    end
    if (cmd_i.commit) begin
      halted_o      <= halt_q;
      jump_taken_o  <= jt_q;
      jump_label_o  <= jt_q ? lab_q : '0;
      reg_written_o <= wr_fin;
      write_index_o <= wr_fin ? ra_q : '0;
      write_value_o <= wr_fin ? wval_q : '0;
      status_o      <= st_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_vld_q    <= '0;
      sd_q        <= '0;
      pushed_q    <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      if (cmd_i.commit) begin
        out_valid_o <= 1'b1;
        if (wr_fin) begin
          rf_vld_q[ra_q[RaW-1:0]] <= 1'b1;
        end
        if (stk_we) begin
          sd_q     <= sd_q + 1'b1;
          pushed_q <= 1'b1;
        end else if (is_pop) begin
          sd_q <= sd_dec;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/register_vm_execute_unit.sv
// ----------------------------------------------------------------------------
// register_vm_execute_unit
// executes one decoded vm instruction per input transfer
// ----------------------------------------------------------------------------
// Each input transfer carries one decoded instruction; the unit runs it
// against a register file of NUM_REGS 32-bit registers and a value stack of
// STACK_DEPTH entries, and returns exactly one result transfer per
// instruction. Instructions are processed one at a time: a transfer is taken
// only when the sequencer is idle, but a finished result waits in the output
// register so the next instruction can already be accepted. Most instructions
// pass through a register file read of reg_a, a read of reg_b, evaluation and
// commit between input transfer and result; the two reads are separate since
// the register file has a single read port. Signed divides by a nonzero
// divisor also wait for the restoring divider, which produces one quotient bit
// per cycle plus a sign fixup. Both the register file and the stack come up as
// zero without a clearing pass: the register file carries one valid bit per
// register, and the stack only reads entries below its fill level, except for
// an underflow pop which returns zero until the first push.
`default_nettype none

module register_vm_execute_unit #(
  parameter int unsigned NUM_REGS    = rvmx_pkg::NumRegsDefault,
  parameter int unsigned STACK_DEPTH = rvmx_pkg::StackDepthDefault
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // instruction input
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // func[4:0], reg_a[12:5], reg_b[20:13], immediate[52:21], label[68:53], zero fill
  input  wire logic [rvmx_pkg::InTdataW-1:0]     s_axis_tdata,
  // result output
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // halted[0], jump_taken[1], jump_label[17:2], reg_written[18],
  // write_index[26:19], write_value[58:27], status[60:59], zero fill
  output logic      [rvmx_pkg::OutTdataW-1:0]    m_axis_tdata
);
  import rvmx_pkg::*;

  cmd_t cmd;
  sts_t sts;

  logic                halted, jump_taken, reg_written;
  logic [LabelW-1:0]   jump_label;
  logic [RegIdxW-1:0]  write_index;
  logic [DataW-1:0]    write_value;
  logic [1:0]          status;

  // sequencer
  rvmx_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // storage, alu, divider and result register
  rvmx_dp #(
    .NUM_REGS    (NUM_REGS),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .func_i        (s_axis_tdata[4:0]),
    .reg_a_i       (s_axis_tdata[12:5]),
    .reg_b_i       (s_axis_tdata[20:13]),
    .immediate_i   (s_axis_tdata[52:21]),
    .label_i       (s_axis_tdata[68:53]),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .halted_o      (halted),
    .jump_taken_o  (jump_taken),
    .jump_label_o  (jump_label),
    .reg_written_o (reg_written),
    .write_index_o (write_index),
    .write_value_o (write_value),
    .status_o      (status)
  );

  // pack the result, lowest field first
  assign m_axis_tdata = {3'b000, status, write_value, write_index, reg_written,
                         jump_label, jump_taken, halted};

  // one instruction at a time: no transfer right after a transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input transfer while an instruction is in flight");

  // a label is only reported with a taken jump
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !jump_taken) |-> (jump_label == '0))
    else $error("jump label without taken jump");

  // no register write means zero index and value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !reg_written) |-> (write_index == '0 && write_value == '0))
    else $error("write fields set without register write");

  // divide by zero never writes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && status == ST_DIVZ) |-> !reg_written)
    else $error("register written on divide by zero");

endmodule

`default_nettype wire

// File: dv/tb_register_vm_execute_unit.sv
// ----------------------------------------------------------------------------
// tb_register_vm_execute_unit
// self-checking stream testbench of the register vm execute unit
// ----------------------------------------------------------------------------
// A queue of instructions (directed corner cases, then random programs) feeds
// a clocked driver with random gaps. A shadow register file and value stack
// predict each result; a clocked monitor with random back-pressure compares
// every result transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_register_vm_execute_unit;
  import rvmx_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NRegs    = NumRegsDefault;
  localparam int unsigned StkDepth = StackDepthDefault;
  localparam int unsigned IdleLimit = 20000;

  typedef struct packed {
    logic [15:0] label;
    logic [31:0] imm;
    logic [7:0]  rb;
    logic [7:0]  ra;
    logic [4:0]  func;
  } instr_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] wval;
    logic [7:0]  widx;
    logic        wr;
    logic [15:0] jlabel;
    logic        jtaken;
    logic        halted;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [InTdataW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;

  always #6 clk_i = ~clk_i;

  register_vm_execute_unit DUT (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  // shadow machine state
  logic [31:0] shadow_regs [NRegs];
  logic [31:0] shadow_stack [StkDepth];
  int unsigned shadow_depth;

  instr_t  pending_instrs[$];
  result_t expected_results[$];
  int      fail_count = 0;
  bit      stim_done = 1'b0;
  bit      hold_off_req = 1'b0;

  function automatic logic [31:0] read_reg(logic [7:0] idx);
    return (idx < NRegs) ? shadow_regs[idx] : 32'd0;
  endfunction

  function automatic logic compare_true(int unsigned sel, logic [31:0] x, logic [31:0] y);
    case (sel)
      0: return x == y;
      1: return x != y;
      2: return $signed(x) > $signed(y);
      3: return $signed(x) < $signed(y);
      4: return $signed(x) >= $signed(y);
      default: return $signed(x) <= $signed(y);
    endcase
  endfunction

  function automatic logic [31:0] signed_quotient(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma, mb, q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q  = ma / mb;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  // executes one instruction on the shadow state and returns its result
  function automatic result_t execute_instr(instr_t in);
    result_t r;
    logic [31:0] va, src;
    logic wr;
    int unsigned fn;
    r  = '0;
    wr = 1'b0;
    fn = in.func;
    va = read_reg(in.ra);
    if (fn == FN_RET) begin
      r.halted = 1'b1;
    end else if (fn == FN_LETI) begin
      wr = 1'b1; r.wval = in.imm;
    end else if (fn == FN_REV) begin
      wr = 1'b1; r.wval = (va == 0) ? 32'd1 : 32'd0;
    end else if (fn == FN_JMP) begin
      r.jtaken = 1'b1;
    end else if (fn >= FN_JEQ && fn <= FN_JLEI) begin
      src = (fn <= FN_JLE) ? read_reg(in.rb) : in.imm;
      r.jtaken = compare_true((fn <= FN_JLE) ? fn - FN_JEQ : fn - FN_JEQI, va, src);
    end else if (fn >= FN_ADDI && fn <= FN_DIV) begin
      src = (fn <= FN_DIVI) ? in.imm : read_reg(in.rb);
      case ((fn - FN_ADDI) % 4)
        0: begin wr = 1'b1; r.wval = va + src; end
        1: begin wr = 1'b1; r.wval = va - src; end
        2: begin wr = 1'b1; r.wval = va * src; end
        default: begin
          if (src == 0) r.status = ST_DIVZ;
          else begin wr = 1'b1; r.wval = signed_quotient(va, src); end
        end
      endcase
    end else if (fn == FN_PUSH) begin
      if (shadow_depth >= StkDepth) r.status = ST_OVER;
      else begin
        shadow_stack[shadow_depth] = va;
        shadow_depth++;
      end
    end else if (fn == FN_POP) begin
      if (shadow_depth == 0) begin
        r.status = ST_UNDER; r.wval = shadow_stack[0];
      end else begin
        shadow_depth--;
        r.wval = shadow_stack[shadow_depth];
      end
      wr = 1'b1;
    end
    if (!r.jtaken) r.jlabel = '0;
    else r.jlabel = in.label;
    if (wr && in.ra >= NRegs) wr = 1'b0;
    if (wr) begin
      shadow_regs[in.ra] = r.wval;
      r.wr = 1'b1; r.widx = in.ra;
    end else begin
      r.wval = '0;
    end
    return r;
  endfunction

  function automatic instr_t make_instr(int unsigned fn, int unsigned ra, int unsigned rb,
                                        logic [31:0] imm, logic [15:0] label);
    instr_t i;
    i.func = fn[4:0]; i.ra = ra[7:0]; i.rb = rb[7:0]; i.imm = imm; i.label = label;
    return i;
  endfunction

  // random immediate biased toward corner values
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'd0;
      4: return $urandom_range(0, 8) - 4;
      default: return $urandom;
    endcase
  endfunction

  // mostly small register set so values chain between instructions
  function automatic int unsigned pick_reg();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 7);
  endfunction

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    int unsigned fn;
    foreach (shadow_regs[k]) shadow_regs[k] = '0;
    foreach (shadow_stack[k]) shadow_stack[k] = '0;
    shadow_depth = 0;

    // underflow on an empty stack returns the never-pushed bottom entry
    pending_instrs.push_back(make_instr(FN_POP, 1, 0, 0, 16'h1234));
    pending_instrs.push_back(make_instr(FN_RET, 0, 0, 0, 0));
    pending_instrs.push_back(make_instr(FN_LETI, 2, 0, 32'h8000_0000, 0));
    pending_instrs.push_back(make_instr(FN_LETI, 3, 0, 32'hffff_ffff, 0));
    pending_instrs.push_back(make_instr(FN_LETI, 255, 0, 32'h7fff_ffff, 0));
    // most negative divided by minus one wraps
    pending_instrs.push_back(make_instr(FN_DIV, 2, 3, 0, 0));
    pending_instrs.push_back(make_instr(FN_DIVI, 3, 0, 0, 0));
    pending_instrs.push_back(make_instr(FN_DIVI, 255, 0, 32'hffff_fff9, 0));
    pending_instrs.push_back(make_instr(FN_REV, 4, 0, 0, 0));
    pending_instrs.push_back(make_instr(FN_REV, 4, 0, 0, 0));
    pending_instrs.push_back(make_instr(FN_JMP, 0, 0, 0, 16'hffff));
    pending_instrs.push_back(make_instr(FN_JLT, 2, 255, 0, 16'h8001));
    pending_instrs.push_back(make_instr(FN_JGTI, 255, 0, 32'h8000_0000, 16'h7ffe));
    pending_instrs.push_back(make_instr(FN_MULI, 255, 0, 32'h7fff_ffff, 0));
    pending_instrs.push_back(make_instr(FN_SUB, 2, 255, 0, 0));
    pending_instrs.push_back(make_instr(FN_PUSH, 255, 0, 0, 0));
    pending_instrs.push_back(make_instr(FN_POP, 5, 0, 0, 0));
    pending_instrs.push_back(make_instr(FN_POP, 6, 0, 0, 0));
    pending_instrs.push_back(make_instr(FN_NOP, 0, 0, 0, 0));
    pending_instrs.push_back(make_instr(31, 255, 255, 32'hffff_ffff, 16'hffff));
    pending_instrs.push_back(make_instr(FN_ADD, 7, 2, 0, 0));
    // overflow: fill the stack past its depth, then drain it past empty
    repeat (StkDepth + 2)
      pending_instrs.push_back(make_instr(FN_PUSH, pick_reg(), 0, 0, 0));
    repeat (StkDepth + 2)
      pending_instrs.push_back(make_instr(FN_POP, pick_reg(), 0, 0, $urandom));

    repeat (560) begin
      fn = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 26);
      pending_instrs.push_back(make_instr(fn, pick_reg(), pick_reg(), pick_value(),
                                          $urandom_range(0, 65535)));
    end
    stim_done = 1'b1;
  end

  // --------------------------------------------------------------------------
  // driver: prediction is made at the accepting edge
  // --------------------------------------------------------------------------
  int unsigned send_gap = 0;
  int unsigned sent_count = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(execute_instr(instr_t'(s_axis_tdata[68:0])));
        sent_count <= sent_count + 1;
        void'(pending_instrs.pop_front());
        send_gap = $urandom_range(0, 6);
        if (send_gap == 0 && pending_instrs.size() > 0) begin
          s_axis_tdata <= {3'b0, pending_instrs[0]};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end else if (!s_axis_tvalid) begin
        if (send_gap > 0) send_gap--;
        else if (pending_instrs.size() > 0 && (stim_done || pending_instrs.size() > 1)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {3'b0, pending_instrs[0]};
        end
      end
    end
  end

  // long receiver hold-off once during the random part, so the block backs up
  initial begin
    wait (sent_count == 600);
    hold_off_req = 1'b1;
    repeat (400) @(posedge clk_i);
    hold_off_req = 1'b0;
  end

  // --------------------------------------------------------------------------
  // monitor with random back-pressure
  // --------------------------------------------------------------------------
  int unsigned recv_gap = 0;
  result_t got;
  result_t want;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata[60:0]);
        if (expected_results.size() == 0) begin
          $error("unexpected result transfer %h", m_axis_tdata);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.halted !== want.halted) begin
            $error("halted: expected %0d actual %0d", want.halted, got.halted); fail_count++;
          end
          if (got.jtaken !== want.jtaken) begin
            $error("jump_taken: expected %0d actual %0d", want.jtaken, got.jtaken); fail_count++;
          end
          if (got.jlabel !== want.jlabel) begin
            $error("jump_label: expected %0d actual %0d", want.jlabel, got.jlabel); fail_count++;
          end
          if (got.wr !== want.wr) begin
            $error("reg_written: expected %0d actual %0d", want.wr, got.wr); fail_count++;
          end
          if (got.widx !== want.widx) begin
            $error("write_index: expected %0d actual %0d", want.widx, got.widx); fail_count++;
          end
          if (got.wval !== want.wval) begin
            $error("write_value: expected %h actual %h", want.wval, got.wval); fail_count++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d actual %0d", want.status, got.status); fail_count++;
          end
        end
        recv_gap = $urandom_range(0, 6);
      end
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
      end else if (recv_gap > 0 && !(m_axis_tvalid && m_axis_tready)) begin
        recv_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= (recv_gap == 0);
      end
    end
  end

  // --------------------------------------------------------------------------
  // watchdog, reset and end of run
  // --------------------------------------------------------------------------
  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("tb_register_vm_execute_unit: FAIL");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (stim_done && pending_instrs.size() == 0 && !s_axis_tvalid);
    wait (expected_results.size() == 0);
    repeat (60) @(posedge clk_i);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("tb_register_vm_execute_unit: PASS");
    end else begin
      $display("tb_register_vm_execute_unit: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
